@@ rtl/lkvc_pkg.sv @@
// Shared types and constants for the LRU key-value cache.
package lkvc_pkg;

  localparam int ENTRIES = 16;
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int CAP_W   = 5;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int CMP_W   = (CAP_W > CNT_W) ? CAP_W : CNT_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic {
    ACT_GET = 1'b0,
    ACT_PUT = 1'b1
  } action_e;

  // One cache line as it moves along the chain.
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

  // Lookup result rippling along the chain.
  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] rdata;
  } look_t;

  // Request broadcast to every cell.
  typedef struct packed {
    logic             en;
    logic             any_hit;
    action_e          action;
    logic             full;
    logic [KEY_W-1:0] key;
  } cmd_t;

endpackage

@@ rtl/lru_key_value_cache.sv @@
// Top level of the fully associative LRU key-value cache.
//
// Fully associative store of lkvc_pkg::ENTRIES key/value pairs kept in a
// chain of cells ordered by recency: cell 0 holds the most recent entry,
// valid entries always sit contiguously from cell 0. A request transfer
// on the slave stream (tuser = action, 0 get / 1 put) is compared against
// every cell at once; the hit flag and hit value ripple down the chain.
// A hit (get or put) moves the entry to cell 0, shifting the cells in
// front of it back by one. A put miss inserts at cell 0, either pushing
// everything back into the first free cell or, when occupancy has reached
// capacity, dropping the entry in the last valid cell. Each request gives
// exactly one result on the master stream: tuser = found, tdata = stored
// value on a get hit, all ones on a get miss, zero for any put. The cells
// update and the result register loads at the accepting edge, and a new
// request is taken in the same cycle as the pending result leaves, so
// throughput is one transfer per clock while the master side keeps up; the
// ripple through the cell chain sets the clock. The capacity register
// (cfg_data_i, 0 reads as 1, values above the cell count saturate) is to be
// written only while the cache is idle, which the block does not enforce;
// lowering it never drops entries at once, later put misses evict instead.
module lru_key_value_cache (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // capacity register write
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lkvc_pkg::CAP_W-1:0]    cfg_data_i,     // [4:0] capacity
  // requests
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [63:0]                   s_axis_tdata,   // [31:0] key, [63:32] value
  input  logic                          s_axis_tuser,   // [0] action
  // results
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [31:0]                   m_axis_tdata,   // [31:0] read_value
  output logic                          m_axis_tuser    // [0] found
);

  localparam int N = lkvc_pkg::ENTRIES;

  logic [lkvc_pkg::CAP_W-1:0] cap_q;
  logic [lkvc_pkg::CNT_W-1:0] occ_q, occ_d;
  logic                       out_valid_q, out_valid_d;
  logic                       found_q, found_d;
  logic [lkvc_pkg::VAL_W-1:0] rdata_q, rdata_d;

  logic [lkvc_pkg::CMP_W-1:0] eff_cap;
  logic                       s_xfer;
  lkvc_pkg::action_e          action;
  logic [lkvc_pkg::KEY_W-1:0] req_key;
  logic [lkvc_pkg::VAL_W-1:0] req_value;
  logic [lkvc_pkg::VAL_W-1:0] ins_value;
  lkvc_pkg::cmd_t             cmd;

  lkvc_pkg::entry_t ent [0:N];
  lkvc_pkg::look_t  lk  [0:N];

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  assign action    = lkvc_pkg::action_e'(s_axis_tuser);
  assign req_key   = s_axis_tdata[31:0];
  assign req_value = s_axis_tdata[63:32];

  // capacity clamp: zero behaves as one, saturate at cell count
  always_comb begin
    eff_cap = lkvc_pkg::CMP_W'(cap_q);
    if (cap_q == '0) begin
      eff_cap = lkvc_pkg::CMP_W'(1);
    end else if (lkvc_pkg::CMP_W'(cap_q) > lkvc_pkg::CMP_W'(N)) begin
      eff_cap = lkvc_pkg::CMP_W'(N);
    end
  end

  assign cmd.en      = s_xfer;
  assign cmd.any_hit = lk[N].hit;
  assign cmd.action  = action;
  assign cmd.full    = lkvc_pkg::CMP_W'(occ_q) >= eff_cap;
  assign cmd.key     = req_key;

  // entry presented to cell 0: promoted or newly inserted line
  assign ins_value   = (action == lkvc_pkg::ACT_PUT) ? req_value : lk[N].rdata;
  assign ent[0].valid = 1'b1;
  assign ent[0].key   = req_key;
  assign ent[0].value = ins_value;
  assign lk[0].hit    = 1'b0;
  assign lk[0].rdata  = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    lkvc_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .cmd_i (cmd),
      .prv_i (i == 0 ? ent[0] : ent[i]),
      .lk_i  (lk[i]),
      .ent_o (ent[i+1]),
      .lk_o  (lk[i+1])
    );
  end

  always_comb begin
    occ_d       = occ_q;
    out_valid_d = out_valid_q;
    found_d     = found_q;
    rdata_d     = rdata_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (s_xfer) begin
      out_valid_d = 1'b1;
      found_d     = lk[N].hit;
      if (action == lkvc_pkg::ACT_PUT) begin
        rdata_d = '0;
        if (!lk[N].hit && !cmd.full) begin
          occ_d = occ_q + lkvc_pkg::CNT_W'(1);
        end
      end else begin
        rdata_d = lk[N].hit ? lk[N].rdata : '1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= lkvc_pkg::CAP_RESET;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q <= found_d;
    rdata_q <= rdata_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = rdata_q;
  assign m_axis_tuser  = found_q;

endmodule

@@ rtl/lkvc_cell.sv @@
// One slot of the recency-ordered chain: compare, hand-over and shift.
module lkvc_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lkvc_pkg::cmd_t  cmd_i,
  input  lkvc_pkg::entry_t prv_i,
  input  lkvc_pkg::look_t lk_i,
  output lkvc_pkg::entry_t ent_o,
  output lkvc_pkg::look_t lk_o
);

  logic                       valid_q, valid_d;
  logic [lkvc_pkg::KEY_W-1:0] key_q, key_d;
  logic [lkvc_pkg::VAL_W-1:0] value_q, value_d;
  logic                       match;
  logic                       shift;

  assign match = valid_q && (key_q == cmd_i.key);

  assign lk_o.hit   = lk_i.hit | match;
  assign lk_o.rdata = lk_i.rdata | (match ? value_q : '0);

  assign ent_o.valid = valid_q;
  assign ent_o.key   = key_q;
  assign ent_o.value = value_q;

  // Cells up to the one being overwritten take their upstream neighbour.
  always_comb begin
    shift = 1'b0;
    if (cmd_i.en) begin
      if (cmd_i.any_hit) begin
        shift = !lk_i.hit;
      end else if (cmd_i.action == lkvc_pkg::ACT_PUT) begin
        shift = cmd_i.full ? valid_q : prv_i.valid;
      end
    end
    valid_d = shift ? prv_i.valid : valid_q;
    key_d   = shift ? prv_i.key   : key_q;
    value_d = shift ? prv_i.value : value_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

endmodule

@@ rtl/lkvc_checker.sv @@
// Port-level checks for the LRU key-value cache, bound to the top level.
module lkvc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // every request transfer yields a result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
    else $error("no result after request transfer");

  // no result appears without a request
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid && !(s_axis_tvalid && s_axis_tready)) |=> !m_axis_tvalid)
    else $error("result without request");

  // a put always returns zero
  a_put_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser) |=> (m_axis_tdata == 32'd0))
    else $error("put returned non-zero data");

  // a miss returns either all ones or zero
  a_miss_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |->
      (m_axis_tdata == 32'hFFFF_FFFF || m_axis_tdata == 32'd0))
    else $error("miss with unexpected data");

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tuser (s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
